// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising edge and suspended while reset is low.
`define SLI_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define SLI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/sli_pkg.sv
package sli_pkg;

  localparam int STRING_COUNT = 6;
  localparam int LINE_W       = 6;
  localparam int ADC_W        = 12;
  localparam int STEP_W       = 12;
  localparam int BAND_COUNT   = 7;
  localparam int THR_W        = STEP_W + 3;
  localparam int BAND_W       = 3;
  localparam int STR_W        = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [BAND_W-1:0] BAND_NONE = 3'd7;
  localparam logic [STR_W-1:0]  TUNED_RST = 3'd1;

  localparam logic              POT_ENABLE_RST = 1'b1;
  localparam logic [STEP_W-1:0] BAND_STEP_RST  = 12'd585;

  localparam logic [CFG_ADDR_W-1:0] ADDR_POT_ENABLE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BAND_STEP  = 3'd4;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_SET    = 2'd1,
    OP_RESET  = 2'd2,
    OP_OFF    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    COL_OFF   = 2'd0,
    COL_GREEN = 2'd1,
    COL_RED   = 2'd2
  } colour_t;

  typedef struct packed {
    op_t                     kind;
    logic [BAND_W-1:0]       band;
    logic [STRING_COUNT-1:0] str_sel;
    colour_t                 colour;
  } cmd_t;

endpackage

// File: design/string_led_indicator_controller_top.sv
// Accepts one item per clock while in_stall is low and returns one result item per
// input item, in order. An accepted item is classified in the front end (its potentiometer
// band is found by comparing the sample against seven precomputed band edges), waits in a
// two-entry queue, and is applied to the LED state by the back end, which registers the
// result. The single update of the LED state per cycle in the back end sets the rate of one
// item per cycle while out_stall does not hold the output. Writing band_step recomputes the
// band edges in the same cycle, so items may follow a configuration write directly.
module string_led_indicator_controller_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_operation,
  input  logic [sli_pkg::ADC_W-1:0]        in_adc_sample,
  input  logic [sli_pkg::STR_W-1:0]        in_string_number,
  input  logic [1:0]                       in_led_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sli_pkg::LINE_W-1:0]       out_green_lines,
  output logic [sli_pkg::LINE_W-1:0]       out_red_lines,
  output logic                             out_single_mode_lamp,
  output logic                             out_six_mode_lamp,
  output logic                             out_mode_now,
  output logic [sli_pkg::STR_W-1:0]        out_selected_string,
  output logic                             out_all_tuned,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sli_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sli_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sli_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import sli_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  sli_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_adc_sample    (in_adc_sample),
    .in_string_number (in_string_number),
    .in_led_value     (in_led_value),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  sli_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  sli_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_cmd                (pop_cmd),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_green_lines      (out_green_lines),
    .out_red_lines        (out_red_lines),
    .out_single_mode_lamp (out_single_mode_lamp),
    .out_six_mode_lamp    (out_six_mode_lamp),
    .out_mode_now         (out_mode_now),
    .out_selected_string  (out_selected_string),
    .out_all_tuned        (out_all_tuned)
  );

endmodule

// File: design/sli_front.sv
module sli_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_operation,
  input  logic [sli_pkg::ADC_W-1:0]        in_adc_sample,
  input  logic [sli_pkg::STR_W-1:0]        in_string_number,
  input  logic [1:0]                       in_led_value,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sli_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sli_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sli_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  input  logic                             q_full,
  output logic                             q_push,
  output sli_pkg::cmd_t                    q_cmd
);
  import sli_pkg::*;

  logic              pot_enable_r;
  logic [STEP_W-1:0] band_step_r;
  logic [THR_W-1:0]  thr_r   [BAND_COUNT];
  logic [THR_W-1:0]  thr_nxt [BAND_COUNT];
  logic              cfg_wr;
  logic [BAND_W-1:0] band_sum;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Band edges are the multiples of the step, rebuilt whenever the step is written.
  always_comb begin
    for (int k = 0; k < BAND_COUNT; k++) begin
      thr_nxt[k] = THR_W'(k + 1) * THR_W'(cfg_pwdata[STEP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_enable_r <= POT_ENABLE_RST;
      band_step_r  <= BAND_STEP_RST;
      for (int k = 0; k < BAND_COUNT; k++) begin
        thr_r[k] <= THR_W'(k + 1) * THR_W'(BAND_STEP_RST);
      end
    end else if (cfg_wr) begin
      if (cfg_paddr == ADDR_POT_ENABLE) begin
        pot_enable_r <= cfg_pwdata[0];
      end
      if (cfg_paddr == ADDR_BAND_STEP) begin
        band_step_r <= cfg_pwdata[STEP_W-1:0];
        thr_r       <= thr_nxt;
      end
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_POT_ENABLE: cfg_prdata = CFG_DATA_W'(pot_enable_r);
      ADDR_BAND_STEP:  cfg_prdata = CFG_DATA_W'(band_step_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // The band is the number of edges the sample reaches; reaching all seven means no band.
  always_comb begin
    band_sum = '0;
    for (int k = 0; k < BAND_COUNT; k++) begin
      band_sum = band_sum + BAND_W'(THR_W'(in_adc_sample) >= thr_r[k]);
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.kind = op_t'(in_operation);
    q_cmd.band = pot_enable_r ? band_sum : BAND_NONE;
    for (int i = 0; i < STRING_COUNT; i++) begin
      q_cmd.str_sel[i] = (in_string_number == STR_W'(i + 1));
    end
    case (in_led_value)
      2'd1:    q_cmd.colour = COL_GREEN;
      2'd2:    q_cmd.colour = COL_RED;
      default: q_cmd.colour = COL_OFF;
    endcase
  end

endmodule

// File: design/sli_queue.sv
`include "assert_macros.svh"

module sli_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sli_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output sli_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import sli_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `SLI_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> !empty, "queue popped while empty")
  `SLI_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

// File: design/sli_back.sv
`include "assert_macros.svh"

module sli_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  sli_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sli_pkg::LINE_W-1:0]    out_green_lines,
  output logic [sli_pkg::LINE_W-1:0]    out_red_lines,
  output logic                          out_single_mode_lamp,
  output logic                          out_six_mode_lamp,
  output logic                          out_mode_now,
  output logic [sli_pkg::STR_W-1:0]     out_selected_string,
  output logic                          out_all_tuned
);
  import sli_pkg::*;

  colour_t           led_r   [STRING_COUNT];
  colour_t           led_nxt [STRING_COUNT];
  colour_t           pend_r  [STRING_COUNT];
  colour_t           pend_nxt[STRING_COUNT];
  logic [1:0]        lamp_r, lamp_nxt;
  logic              mode_r, mode_nxt;
  logic [STR_W-1:0]  tuned_r, tuned_nxt;
  logic [BAND_W-1:0] last_band_r, last_band_nxt;
  colour_t           set_col;
  logic [LINE_W-1:0] green_nxt, red_nxt;
  logic              all_tuned_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0] green_r, red_r;
  logic              all_tuned_r;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    led_nxt       = led_r;
    pend_nxt      = pend_r;
    lamp_nxt      = lamp_r;
    mode_nxt      = mode_r;
    tuned_nxt     = tuned_r;
    last_band_nxt = last_band_r;
    set_col       = q_cmd.colour;
    case (q_cmd.kind)
      OP_SAMPLE: begin
        if (q_cmd.band != BAND_NONE && q_cmd.band != last_band_r) begin
          last_band_nxt = q_cmd.band;
          if (q_cmd.band < BAND_W'(STRING_COUNT)) begin
            lamp_nxt  = 2'b01;
            mode_nxt  = 1'b0;
            tuned_nxt = STR_W'(q_cmd.band + 1'b1);
            for (int i = 0; i < STRING_COUNT; i++) begin
              led_nxt[i]  = (q_cmd.band == BAND_W'(i)) ? COL_RED : COL_OFF;
              pend_nxt[i] = (q_cmd.band == BAND_W'(i)) ? COL_RED : COL_OFF;
            end
          end else begin
            lamp_nxt  = 2'b10;
            mode_nxt  = 1'b1;
            tuned_nxt = '0;
            for (int i = 0; i < STRING_COUNT; i++) begin
              led_nxt[i]  = COL_RED;
              pend_nxt[i] = COL_RED;
            end
          end
        end
      end
      OP_SET: begin
        if (!mode_r && set_col == COL_RED) begin
          set_col = COL_OFF;
        end
        for (int i = 0; i < STRING_COUNT; i++) begin
          if (q_cmd.str_sel[i]) begin
            pend_nxt[i] = set_col;
          end
          if (led_r[i] != COL_GREEN) begin
            led_nxt[i] = pend_nxt[i];
          end
        end
      end
      OP_RESET: begin
        for (int i = 0; i < STRING_COUNT; i++) begin
          if (mode_r || tuned_r == STR_W'(i + 1)) begin
            led_nxt[i]  = COL_RED;
            pend_nxt[i] = COL_RED;
          end else begin
            led_nxt[i]  = COL_OFF;
            pend_nxt[i] = COL_OFF;
          end
        end
      end
      default: begin
        lamp_nxt = 2'b00;
        for (int i = 0; i < STRING_COUNT; i++) begin
          led_nxt[i]  = COL_OFF;
          pend_nxt[i] = COL_OFF;
        end
      end
    endcase
  end

  always_comb begin
    green_nxt = '0;
    red_nxt   = '0;
    for (int i = 0; i < STRING_COUNT; i++) begin
      green_nxt[i] = (led_nxt[i] == COL_GREEN);
      red_nxt[i]   = (led_nxt[i] == COL_RED);
    end
    all_tuned_nxt = mode_nxt ? (green_nxt[STRING_COUNT-1:0] == '1) : (green_nxt != '0);
  end

  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STRING_COUNT; i++) begin
        led_r[i]  <= COL_OFF;
        pend_r[i] <= COL_OFF;
      end
      lamp_r      <= 2'b00;
      mode_r      <= 1'b0;
      tuned_r     <= TUNED_RST;
      last_band_r <= BAND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        led_r       <= led_nxt;
        pend_r      <= pend_nxt;
        lamp_r      <= lamp_nxt;
        mode_r      <= mode_nxt;
        tuned_r     <= tuned_nxt;
        last_band_r <= last_band_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      green_r     <= green_nxt;
      red_r       <= red_nxt;
      all_tuned_r <= all_tuned_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_green_lines      = green_r;
  assign out_red_lines        = red_r;
  assign out_single_mode_lamp = lamp_r[0];
  assign out_six_mode_lamp    = lamp_r[1];
  assign out_mode_now         = mode_r;
  assign out_selected_string  = tuned_r;
  assign out_all_tuned        = all_tuned_r;

  `SLI_ASSERT(a_lamps_exclusive, clk, rst_n, lamp_r != 2'b11, "both mode lamps lit")
  `SLI_ASSERT(a_lines_exclusive, clk, rst_n, out_valid |-> (out_green_lines & out_red_lines) == '0,
              "string driven green and red at once")
  `SLI_ASSERT(a_six_mode_no_string, clk, rst_n, mode_r |-> tuned_r == '0,
              "six-string mode with a tuned string")

endmodule

// File: bench/string_led_indicator_controller_top_tb.sv
`timescale 1ns / 1ps

module string_led_indicator_controller_top_tb;
  import sli_pkg::*;

  localparam int IDLE_LIMIT = 400;
  localparam int SHOW_LIMIT = 40;

  typedef struct packed {
    logic [LINE_W-1:0] green;
    logic [LINE_W-1:0] red;
    logic              single_lamp;
    logic              six_lamp;
    logic              mode;
    logic [STR_W-1:0]  sel;
    logic              tuned;
  } indicator_t;

  typedef struct {
    op_t              op;
    logic [ADC_W-1:0] adc;
    logic [STR_W-1:0] num;
    logic [1:0]       val;
    bit               typed;
    indicator_t       want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_operation = 2'd0;
  logic [ADC_W-1:0]      in_adc_sample = '0;
  logic [STR_W-1:0]      in_string_number = '0;
  logic [1:0]            in_led_value = 2'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LINE_W-1:0]     out_green_lines;
  logic [LINE_W-1:0]     out_red_lines;
  logic                  out_single_mode_lamp;
  logic                  out_six_mode_lamp;
  logic                  out_mode_now;
  logic [STR_W-1:0]      out_selected_string;
  logic                  out_all_tuned;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  bit                    item_typed = 1'b0;
  indicator_t            item_want = '0;

  string_led_indicator_controller_top uut (.*);

  always #2 clk = ~clk;

  colour_t          m_led [STRING_COUNT];
  colour_t          m_pend [STRING_COUNT];
  logic [1:0]       m_lamps;
  logic             m_mode;
  logic [STR_W-1:0] m_tuned;
  logic [2:0]       m_last_band;
  logic             m_pot_en;
  logic [STEP_W-1:0] m_step;

  indicator_t expected_indicators[$];
  stim_row_t  directed_rows[$];
  int         err_count = 0;
  int         shown = 0;
  int         idle_cycles = 0;
  bit         idle_on = 1'b1;
  int         stall_left = 0;

  function automatic void fill_strings(colour_t c);
    for (int i = 0; i < STRING_COUNT; i++) begin
      m_led[i] = c;
      m_pend[i] = c;
    end
  endfunction

  function automatic void strings_dark();
    fill_strings(COL_OFF);
    m_lamps = 2'b00;
  endfunction

  function automatic void reset_model();
    strings_dark();
    m_mode = 1'b0;
    m_tuned = TUNED_RST;
    m_last_band = BAND_NONE;
    m_pot_en = POT_ENABLE_RST;
    m_step = BAND_STEP_RST;
  endfunction

  // Applies one item to the predicted LED state and returns the indicator it shows.
  function automatic indicator_t indicator_after(op_t op, logic [ADC_W-1:0] adc,
                                                 logic [STR_W-1:0] num, logic [1:0] val);
    int         band;
    int         greens;
    colour_t    c;
    indicator_t res;
    greens = 0;
    res = '0;
    case (op)
      OP_SAMPLE: begin
        if (m_pot_en && m_step != 0) begin
          band = int'(adc) / int'(m_step);
          if (band < BAND_COUNT && band != int'(m_last_band)) begin
            m_last_band = band[2:0];
            if (band < STRING_COUNT) begin
              strings_dark();
              m_lamps = 2'b01;
              m_mode = 1'b0;
              m_led[band] = COL_RED;
              m_pend[band] = COL_RED;
              m_tuned = 3'(band + 1);
            end else begin
              fill_strings(COL_RED);
              m_lamps = 2'b10;
              m_mode = 1'b1;
              m_tuned = '0;
            end
          end
        end
      end
      OP_SET: begin
        c = (val == 2'd3) ? COL_OFF : colour_t'(val);
        if (!m_mode && c == COL_RED) c = COL_OFF;
        if (num >= 1 && num <= STRING_COUNT) m_pend[num - 1] = c;
        for (int i = 0; i < STRING_COUNT; i++) begin
          if (m_led[i] != COL_GREEN) m_led[i] = m_pend[i];
        end
      end
      OP_RESET: begin
        if (m_mode) begin
          fill_strings(COL_RED);
        end else begin
          fill_strings(COL_OFF);
          if (m_tuned >= 1 && m_tuned <= STRING_COUNT) begin
            m_led[m_tuned - 1] = COL_RED;
            m_pend[m_tuned - 1] = COL_RED;
          end
        end
      end
      default: strings_dark();
    endcase
    for (int i = 0; i < STRING_COUNT; i++) begin
      if (m_led[i] == COL_GREEN) begin
        res.green[i] = 1'b1;
        greens++;
      end else if (m_led[i] == COL_RED) begin
        res.red[i] = 1'b1;
      end
    end
    res.single_lamp = m_lamps[0];
    res.six_lamp = m_lamps[1];
    res.mode = m_mode;
    res.sel = m_tuned;
    res.tuned = m_mode ? (greens == STRING_COUNT) : (greens != 0);
    return res;
  endfunction

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      err_count++;
      if (shown < SHOW_LIMIT) begin
        shown++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    indicator_t got;
    indicator_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        want = indicator_after(op_t'(in_operation), in_adc_sample, in_string_number,
                               in_led_value);
        expected_indicators.push_back(item_typed ? item_want : want);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got = {out_green_lines, out_red_lines, out_single_mode_lamp, out_six_mode_lamp,
               out_mode_now, out_selected_string, out_all_tuned};
        if (expected_indicators.size() == 0) begin
          err_count++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("%0t: result with nothing expected, expected none, actual %0h",
                     $time, got);
          end
        end else begin
          want = expected_indicators.pop_front();
          report_field("green_lines", want.green, got.green);
          report_field("red_lines", want.red, got.red);
          report_field("single_mode_lamp", want.single_lamp, got.single_lamp);
          report_field("six_mode_lamp", want.six_lamp, got.six_lamp);
          report_field("mode_now", want.mode, got.mode);
          report_field("selected_string", want.sel, got.sel);
          report_field("all_tuned", want.tuned, got.tuned);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= (stall_left > 1);
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 19);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic add_row(op_t op, int adc, int num, int val, bit typed, int green, int red,
                         int single_lamp, int six_lamp, int mode, int sel, int tuned);
    stim_row_t row;
    row.op = op;
    row.adc = adc[ADC_W-1:0];
    row.num = num[STR_W-1:0];
    row.val = val[1:0];
    row.typed = typed;
    row.want = {green[LINE_W-1:0], red[LINE_W-1:0], single_lamp[0], six_lamp[0], mode[0],
                sel[STR_W-1:0], tuned[0]};
    directed_rows.push_back(row);
  endtask

  task automatic send_item(op_t op, logic [ADC_W-1:0] adc, logic [STR_W-1:0] num,
                           logic [1:0] val, bit typed, indicator_t want);
    in_valid <= 1'b1;
    in_operation <= op;
    in_adc_sample <= adc;
    in_string_number <= num;
    in_led_value <= val;
    item_typed <= typed;
    item_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_indicators.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data,
                           logic [CFG_DATA_W-1:0] mask);
    logic [CFG_DATA_W-1:0] rd;
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if ((rd & mask) != (data & mask)) begin
      err_count++;
      $display("%0t: register %0h read back, expected %0h, actual %0h", $time, addr,
               data & mask, rd & mask);
    end
  endtask

  task automatic program_regs(logic en, logic [STEP_W-1:0] step);
    write_reg(ADDR_POT_ENABLE, CFG_DATA_W'(en), CFG_DATA_W'(1));
    m_pot_en = en;
    write_reg(ADDR_BAND_STEP, CFG_DATA_W'(step), CFG_DATA_W'(12'hFFF));
    m_step = step;
  endtask

  // Most samples land inside a chosen band so that mode changes happen often.
  function automatic logic [ADC_W-1:0] pick_sample();
    int band;
    int v;
    if (m_step == 0 || $urandom_range(0, 3) == 0) return ADC_W'($urandom_range(0, 4095));
    band = $urandom_range(0, 7);
    v = band * int'(m_step) + int'($urandom_range(0, int'(m_step) - 1));
    return ADC_W'((v > 4095) ? 4095 : v);
  endfunction

  task automatic run_phase(logic en, logic [STEP_W-1:0] step, int count, bit idle);
    int               r;
    op_t              op;
    logic [STR_W-1:0] num;
    logic [1:0]       val;
    drain_results();
    program_regs(en, step);
    idle_on = idle;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      op = (r < 30) ? OP_SAMPLE : (r < 80) ? OP_SET : (r < 92) ? OP_RESET : OP_OFF;
      if ($urandom_range(0, 9) == 0) num = $urandom_range(0, 1) ? 3'd7 : 3'd0;
      else num = STR_W'($urandom_range(1, STRING_COUNT));
      r = $urandom_range(0, 9);
      val = (r < 5) ? COL_GREEN : (r < 7) ? COL_RED : (r < 9) ? COL_OFF : 2'd3;
      send_item(op, pick_sample(), num, val, 1'b0, '0);
    end
  endtask

  initial begin
    reset_model();
    add_row(OP_OFF,    0,    0, 0,         1, 'h00, 'h00, 0, 0, 0, 1, 0);
    add_row(OP_SAMPLE, 0,    0, 0,         1, 'h00, 'h01, 1, 0, 0, 1, 0);
    add_row(OP_SAMPLE, 100,  0, 0,         1, 'h00, 'h01, 1, 0, 0, 1, 0);
    add_row(OP_SAMPLE, 4095, 0, 0,         1, 'h00, 'h01, 1, 0, 0, 1, 0);
    add_row(OP_SAMPLE, 4094, 0, 0,         1, 'h00, 'h3F, 0, 1, 1, 0, 0);
    add_row(OP_SET,    0,    1, COL_GREEN, 1, 'h01, 'h3E, 0, 1, 1, 0, 0);
    add_row(OP_SET,    0,    0, COL_GREEN, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_SET,    0,    7, 3,         0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_SET,    0,    6, COL_RED,   0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_RESET,  0,    0, 0,         1, 'h00, 'h3F, 0, 1, 1, 0, 0);
    for (int s = 1; s < STRING_COUNT; s++) add_row(OP_SET, 0, s, COL_GREEN, 0,
                                                   0, 0, 0, 0, 0, 0, 0);
    add_row(OP_SET,    0,    6, COL_GREEN, 1, 'h3F, 'h00, 0, 1, 1, 0, 1);
    add_row(OP_SAMPLE, 1755, 0, 0,         1, 'h00, 'h08, 1, 0, 0, 4, 0);
    add_row(OP_SET,    0,    4, COL_RED,   0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_SET,    0,    2, 3,         0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_SET,    0,    2, COL_GREEN, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_RESET,  0,    0, 0,         1, 'h00, 'h08, 1, 0, 0, 4, 0);
    add_row(OP_OFF,    0,    0, 0,         1, 'h00, 'h00, 0, 0, 0, 4, 0);
    add_row(OP_RESET,  0,    0, 0,         0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_SAMPLE, 2925, 0, 0,         0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_SAMPLE, 3510, 0, 0,         0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_SAMPLE, 584,  0, 0,         0, 0, 0, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].adc, directed_rows[i].num,
                directed_rows[i].val, directed_rows[i].typed, directed_rows[i].want);
    end

    run_phase(1'b1, 12'd585, 90, 1'b1);
    run_phase(1'b0, 12'd585, 60, 1'b1);
    run_phase(1'b1, 12'd1, 90, 1'b1);
    run_phase(1'b1, 12'd4095, 80, 1'b1);
    run_phase(1'b1, 12'd0, 40, 1'b1);
    run_phase(1'b1, STEP_W'($urandom_range(2, 4094)), 100, 1'b1);
    run_phase(1'b1, 12'd585, 170, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
